// File: rtl/pba_pkg.sv
// pba_pkg: shared types and constants of the page bitmap allocator
// word layouts, status codes, controller states and the control/datapath link
// no dependencies
package pba_pkg;

    localparam int WORD_W        = 64;
    localparam int WORD_LOG      = 6;
    localparam int DEF_NUM_PAGES = 4096;
    localparam int INDEX_W       = 12;
    localparam int COUNT_W       = 13;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_NOFIT = 2'd1,
        STAT_NULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic               cmd;
        logic [INDEX_W-1:0] page_index;
        logic [COUNT_W-1:0] run_len;
    } t_in_word;

    typedef struct packed {
        logic [INDEX_W-1:0] alloc_page;
        logic [1:0]         status;
    } t_out_word;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_FREE,
        S_SCAN_INIT,
        S_SCAN_RD,
        S_SCAN_PREP,
        S_SCAN_EVAL,
        S_MARK,
        S_DONE
    } t_state;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic clr_wr;
        logic free_setup;
        logic scan_init;
        logic from_zero;
        logic prep;
        logic eval;
        logic mark_wr;
        logic hint_clr;
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic is_free;
        logic idx_zero;
        logic free_empty;
        logic alloc_bad;
        logic hint_over;
        logic hint_zero;
        logic found;
        logic scan_last;
        logic mark_last;
        logic clr_last;
    } t_dp_stat;

endpackage

// File: rtl/pba_ctrl.sv
// pba_ctrl: sequencing state machine of the page bitmap allocator
// drives the datapath through t_dp_cmd and reads back t_dp_stat
// depends on pba_pkg
module pba_ctrl import pba_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    input  logic     i_out_free,
    output t_dp_cmd  o_cmd,
    output logic     o_done,
    output t_status  o_code
);

    t_state  r_state, n_state;
    logic    r_second, n_second;
    t_status r_code, n_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_second <= 1'b0;
            r_code   <= STAT_OK;
        end else begin
            r_state  <= n_state;
            r_second <= n_second;
            r_code   <= n_code;
        end
    end

    // next state
    always_comb begin
        n_state  = r_state;
        n_second = r_second;
        n_code   = r_code;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                n_second = 1'b0;
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (i_stat.is_free) begin
                    if (i_stat.idx_zero) begin
                        n_code  = STAT_NULL;
                        n_state = S_DONE;
                    end else begin
                        n_code  = STAT_OK;
                        n_state = i_stat.free_empty ? S_DONE : S_FREE;
                    end
                end else if (i_stat.alloc_bad) begin
                    n_code  = STAT_NOFIT;
                    n_state = S_DONE;
                end else begin
                    n_state = S_SCAN_INIT;
                end
            end
            S_FREE, S_MARK: begin
                if (i_stat.mark_last) n_state = S_DONE;
            end
            S_SCAN_INIT: begin
                // hint past the map: the first pass is empty, go straight to the retry
                if (!r_second && i_stat.hint_over) n_second = 1'b1;
                n_state = S_SCAN_RD;
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_PREP;
            end
            S_SCAN_PREP: begin
                n_state = S_SCAN_EVAL;
            end
            S_SCAN_EVAL: begin
                if (i_stat.found) begin
                    n_code  = STAT_OK;
                    n_state = S_MARK;
                end else if (i_stat.scan_last) begin
                    if (!r_second && !i_stat.hint_zero) begin
                        n_second = 1'b1;
                        n_state  = S_SCAN_INIT;
                    end else begin
                        n_code  = STAT_NOFIT;
                        n_state = S_DONE;
                    end
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_DONE: begin
                if (i_out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_done     = 1'b0;
        o_code     = r_code;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_DECODE: begin
                o_cmd.free_setup = i_stat.is_free && !i_stat.idx_zero;
                o_cmd.hint_clr   = !i_stat.is_free && i_stat.alloc_bad;
            end
            S_FREE, S_MARK: begin
                o_cmd.mark_wr = 1'b1;
            end
            S_SCAN_INIT: begin
                o_cmd.scan_init = 1'b1;
                o_cmd.from_zero = r_second || i_stat.hint_over;
            end
            S_SCAN_PREP: begin
                o_cmd.prep = 1'b1;
            end
            S_SCAN_EVAL: begin
                o_cmd.eval     = 1'b1;
                o_cmd.hint_clr = !i_stat.found && i_stat.scan_last
                                 && (r_second || i_stat.hint_zero);
            end
            S_DONE: begin
                o_done = i_out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/pba_dp.sv
// pba_dp: used-page bitmap memory, run search and range marking datapath
// one 64-bit map word is read, searched or written per step
// depends on pba_pkg
module pba_dp import pba_pkg::*; #(
    parameter int NUM_PAGES = DEF_NUM_PAGES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_in_word           i_in_word,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    output logic [INDEX_W-1:0] o_page
);

    localparam int MAP_WORDS = (NUM_PAGES + WORD_W - 1) / WORD_W;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int PW        = $clog2(NUM_PAGES + 1);
    localparam int VW        = (PW > INDEX_W + 2) ? PW : INDEX_W + 2;
    localparam int LAST_BITS = NUM_PAGES - (MAP_WORDS - 1) * WORD_W;
    localparam logic [WORD_W-1:0] ONES      = {WORD_W{1'b1}};
    localparam logic [WORD_W-1:0] LAST_MASK = ONES >> (WORD_W - LAST_BITS);
    localparam logic [AW-1:0]     LAST_WORD = AW'(MAP_WORDS - 1);
    localparam logic [VW-1:0]     NUM_V     = VW'(NUM_PAGES);
    localparam logic [VW-1:0]     WORD_V    = VW'(WORD_W);

    logic [WORD_W-1:0] mem [MAP_WORDS];

    logic               r_cmd;
    logic [INDEX_W-1:0] r_index;
    logic [COUNT_W-1:0] r_count;
    logic [VW-1:0]      r_hint, r_from, r_run, r_first, r_lo, r_hi;
    logic [AW-1:0]      r_waddr;
    logic               r_set;
    logic [WORD_W-1:0]  r_rdata;
    logic [WORD_W-1:0]  r_pf_free, r_pf_s;
    logic               r_pf_all, r_pf_aok;

    logic [VW-1:0]       count_v, index_v, free_sum, free_hi, hi_last, base;
    logic [VW-1:0]       need, start, start_end;
    logic [AW-1:0]       from_word, lo_word, hi_word;
    logic [WORD_W-1:0]   fw, low_mask, s_mask, bmask, wmask;
    logic [WORD_LOG-1:0] lo_off, hi_off, s_idx;
    logic [WORD_LOG:0]   top_free;
    logic                a_ok, s_any, found, wval, we;
    logic [WORD_W:0]     g [WORD_LOG+1];
    logic [WORD_W:0]     acc;

    assign count_v   = VW'(r_count);
    assign index_v   = VW'(r_index);
    assign free_sum  = index_v + count_v;
    assign free_hi   = (free_sum > NUM_V) ? NUM_V : free_sum;
    assign from_word = r_from[WORD_LOG +: AW];
    assign lo_word   = r_lo[WORD_LOG +: AW];
    assign hi_last   = r_hi - VW'(1);
    assign hi_word   = hi_last[WORD_LOG +: AW];
    assign base      = VW'({r_waddr, {WORD_LOG{1'b0}}});

    // word search, first half: free bits, carried-run test, run start mask
    always_comb begin
        fw = ~r_rdata;
        if (r_waddr == from_word) fw = fw & (ONES << r_from[WORD_LOG-1:0]);
        if (r_waddr == LAST_WORD) fw = fw & LAST_MASK;

        need     = count_v - r_run;
        low_mask = ONES >> ((WORD_LOG+1)'(WORD_W) - need[WORD_LOG:0]);
        a_ok     = (need <= WORD_V) && (&(fw | ~low_mask));

        // g[k] marks free runs of 2**k pages starting at each bit
        g[0] = {1'b0, fw};
        for (int k = 0; k < WORD_LOG; k++) begin
            g[k+1] = g[k] & (g[k] >> (1 << k));
        end
        acc = {(WORD_W+1){1'b1}};
        for (int k = WORD_LOG; k >= 0; k--) begin
            if (r_count[k]) acc = g[k] & (acc >> (1 << k));
        end
        s_mask = (count_v > WORD_V) ? '0 : acc[WORD_W-1:0];
    end

    // word search, second half: pick the run or carry the tail
    always_comb begin
        s_idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (r_pf_s[i]) s_idx = WORD_LOG'(i);
        end
        top_free = (WORD_LOG+1)'(WORD_W);
        for (int i = 0; i < WORD_W; i++) begin
            if (!r_pf_free[i]) top_free = (WORD_LOG+1)'(WORD_W - 1 - i);
        end
        s_any = |r_pf_s;
        found = r_pf_aok || s_any;
        if (r_pf_aok) begin
            start = (r_run == '0) ? base : r_first;
        end else begin
            start = base + VW'(s_idx);
        end
        start_end = start + count_v;
    end

    // bit enables of one word of a run
    always_comb begin
        lo_off = (r_waddr == lo_word) ? r_lo[WORD_LOG-1:0] : '0;
        hi_off = (r_waddr == hi_word) ? hi_last[WORD_LOG-1:0] : {WORD_LOG{1'b1}};
        bmask  = (ONES << lo_off) & (ONES >> ({WORD_LOG{1'b1}} - hi_off));
        wmask  = i_cmd.clr_wr ? ONES : bmask;
        wval   = i_cmd.clr_wr ? 1'b1 : r_set;
        we     = i_cmd.clr_wr || i_cmd.mark_wr;
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[r_waddr];
        if (we) begin
            for (int j = 0; j < WORD_W; j++) begin
                if (wmask[j]) mem[r_waddr][j] <= wval;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waddr <= '0;
            r_hint  <= '0;
        end else begin
            if (i_cmd.clr_wr || i_cmd.mark_wr) r_waddr <= r_waddr + AW'(1);
            if (i_cmd.free_setup) begin
                r_waddr <= index_v[WORD_LOG +: AW];
                r_hint  <= index_v;
            end
            if (i_cmd.scan_init) begin
                r_waddr <= i_cmd.from_zero ? '0 : r_hint[WORD_LOG +: AW];
            end
            if (i_cmd.eval) begin
                if (found) begin
                    r_waddr <= start[WORD_LOG +: AW];
                    r_hint  <= start_end;
                end else begin
                    r_waddr <= r_waddr + AW'(1);
                end
            end
            if (i_cmd.hint_clr) r_hint <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= i_in_word.cmd;
            r_index <= i_in_word.page_index;
            r_count <= i_in_word.run_len;
        end
        if (i_cmd.free_setup) begin
            r_lo  <= index_v;
            r_hi  <= free_hi;
            r_set <= 1'b0;
        end
        if (i_cmd.scan_init) begin
            r_from  <= i_cmd.from_zero ? '0 : r_hint;
            r_run   <= '0;
            r_first <= '0;
        end
        if (i_cmd.prep) begin
            r_pf_free <= fw;
            r_pf_s    <= s_mask;
            r_pf_all  <= &fw;
            r_pf_aok  <= a_ok;
        end
        if (i_cmd.eval) begin
            if (found) begin
                r_lo  <= start;
                r_hi  <= start_end;
                r_set <= 1'b1;
            end else if (r_pf_all) begin
                if (r_run == '0) r_first <= base;
                r_run <= r_run + WORD_V;
            end else begin
                r_run   <= VW'(top_free);
                r_first <= base + VW'((WORD_LOG+1)'(WORD_W) - top_free);
            end
        end
    end

    always_comb begin
        o_stat.is_free    = (r_cmd == CMD_FREE);
        o_stat.idx_zero   = (r_index == '0);
        o_stat.free_empty = (index_v >= NUM_V) || (r_count == '0);
        o_stat.alloc_bad  = (r_count == '0) || (count_v > NUM_V);
        o_stat.hint_over  = (r_hint >= NUM_V);
        o_stat.hint_zero  = (r_hint == '0);
        o_stat.found      = found;
        o_stat.scan_last  = (r_waddr == LAST_WORD);
        o_stat.mark_last  = (r_waddr == hi_word);
        o_stat.clr_last   = (r_waddr == LAST_WORD);
    end

    assign o_page = (r_cmd == CMD_FREE) ? '0 : r_lo[INDEX_W-1:0];

    // page 0 is never freed, so no run may begin there
    a_start_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.eval && found) |-> (start != '0))
        else $error("allocation found at page 0");

    a_run_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.eval && found) |-> (start_end <= NUM_V))
        else $error("allocated run ends past the map");

    a_mark_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mark_wr |-> (r_waddr >= lo_word && r_waddr <= hi_word))
        else $error("map write outside the run");

    a_hint_past_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.eval && found) |=> (r_set && r_hint == r_hi))
        else $error("hint not moved past the allocated run");

endmodule

// File: rtl/page_bitmap_allocator.sv
// page_bitmap_allocator: next-fit page allocator over a used-page bitmap
//
// channels: input words (cmd, page_index, run_len) on i_in_valid/o_in_ready,
// result words (alloc_page, status) on o_out_valid/i_out_ready; a word moves
// when valid and ready are both high at a rising edge of i_clk
// reset: i_rst_n low for one edge; afterwards a clearing pass writes every map
// word to all-used, one 64-page word a cycle, and o_in_ready stays low until
// it is done
// one command is worked at a time; the bitmap memory moves one word per step
// free: decode, then one write step per map word touched, then the result
// is registered; allocate: each map word scanned takes a read, a search and a
// decide step, then one write step per map word marked; a restart from page 0
// adds a second pass over the map
// the result sits in an output register; the next command is taken while it
// waits, and a finished command holds in place until that register is free
// depends on pba_pkg, pba_ctrl, pba_dp
module page_bitmap_allocator import pba_pkg::*; #(
    parameter int NUM_PAGES = DEF_NUM_PAGES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    t_dp_cmd            dp_cmd;
    t_dp_stat           dp_stat;
    logic [INDEX_W-1:0] dp_page;
    logic               done;
    t_status            code;
    logic               out_free;
    logic               r_out_valid;
    t_out_word          r_out;

    assign out_free = !r_out_valid || i_out_ready;

    pba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .i_out_free (out_free),
        .o_cmd      (dp_cmd),
        .o_done     (done),
        .o_code     (code)
    );

    pba_dp #(
        .NUM_PAGES (NUM_PAGES)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_word (i_in_word),
        .i_cmd     (dp_cmd),
        .o_stat    (dp_stat),
        .o_page    (dp_page)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out.alloc_page <= (code == STAT_OK) ? dp_page : '0;
            r_out.status     <= code;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule
